// ===== rtl/vsc_pkg.sv =====
// Shared types and constants for the Vigenere stream cipher.
// No dependencies; used by every module in the block.
package vsc_pkg;

	// Alphabet and key packing
	localparam int unsigned ALPHA_COUNT      = 26;
	localparam int unsigned LETTER_W         = 5;
	localparam int unsigned LETTERS_PER_WORD = 12;
	localparam int unsigned KEY_WORDS        = 4;
	localparam int unsigned WORD_W           = LETTERS_PER_WORD * LETTER_W;
	localparam int unsigned KEY_FLAT_W       = KEY_WORDS * WORD_W;
	localparam int unsigned POS_W            = 6;
	localparam int unsigned CFG_IDX_W        = 3;

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_A        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_B        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_C        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_D        = 3'd5;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       msg_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       was_letter;
	} out_item_t;

	// Per-item control broadcast to every cell of the key row
	typedef struct packed {
		logic             restart;  // message start: token back to cell 0
		logic [POS_W-1:0] eff_len;  // key length clamped to 1..KEY_MAX
	} cell_ctrl_t;

	// Key letter values 26..31 clamp to Z
	function automatic logic [LETTER_W-1:0] sat_letter(input logic [LETTER_W-1:0] v);
		logic [LETTER_W-1:0] lim;
		lim = LETTER_W'(ALPHA_COUNT - 1);
		return (v > lim) ? lim : v;
	endfunction

endpackage

// ===== rtl/vsc_cell.sv =====
// One cell of the key row: holds one bit of the one-hot key position token
// and offers its key letter when it owns the token. Depends on vsc_pkg.
module vsc_cell #(
	parameter int unsigned INDEX = 0
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  vsc_pkg::cell_ctrl_t             ctrl,
	input  logic                            step,      // letter transfer: token moves on
	input  logic [vsc_pkg::LETTER_W-1:0]    letter,
	input  logic                            tok_in,    // neighbor's live token (wrap for cell 0)
	input  logic                            stale_in,  // token sits beyond the key length
	output logic                            tok_live,
	output logic                            stale_out,
	output logic                            last_out,
	output logic [vsc_pkg::LETTER_W-1:0]    key_out
);
	import vsc_pkg::*;

	localparam logic [POS_W-1:0] MY_POS  = POS_W'(INDEX);
	localparam bit               IS_HEAD = (INDEX == 0);

	logic tok_q;
	logic in_range;
	logic tok_d;

	assign in_range = (MY_POS < ctrl.eff_len);

	// Live token: a stale position or a restart falls back to the head cell
	always_comb begin
		if (IS_HEAD) begin
			tok_live = ctrl.restart | tok_q | stale_in;
		end else begin
			tok_live = ~ctrl.restart & tok_q & in_range;
		end
	end

	assign stale_out = tok_q & ~in_range;
	assign last_out  = tok_live & (MY_POS == ctrl.eff_len - POS_W'(1));
	assign key_out   = tok_live ? sat_letter(letter) : '0;

	// Next token: advance on a letter, reset on a bare restart, else hold
	always_comb begin
		if (step) begin
			tok_d = IS_HEAD ? tok_in : (tok_in & in_range);
		end else if (ctrl.restart) begin
			tok_d = IS_HEAD;
		end else begin
			tok_d = tok_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= IS_HEAD;
		end else begin
			tok_q <= tok_d;
		end
	end

endmodule

// ===== rtl/vsc_shift.sv =====
// Letter classifier and modulo-26 shifter for one text byte.
// Depends on vsc_pkg.
module vsc_shift (
	input  logic [7:0]                   in_byte,
	input  logic [vsc_pkg::LETTER_W-1:0] key,
	input  logic                         decrypt,
	output vsc_pkg::out_item_t           result
);
	import vsc_pkg::*;

	logic                is_upper;
	logic                is_lower;
	logic [7:0]          offset;
	logic [LETTER_W-1:0] plain;
	logic [LETTER_W:0]   sum;
	logic [LETTER_W:0]   wrapped;

	assign is_upper = (in_byte >= CHAR_UPPER_A) && (in_byte <= CHAR_UPPER_Z);
	assign is_lower = (in_byte >= CHAR_LOWER_A) && (in_byte <= CHAR_LOWER_Z);

	// Fold case to a letter number 0..25
	assign offset = in_byte - (is_lower ? CHAR_LOWER_A : CHAR_UPPER_A);
	assign plain  = offset[LETTER_W-1:0];

	// Sum stays below 52, so one conditional subtract gives the modulus
	always_comb begin
		if (decrypt) begin
			sum = {1'b0, plain} + (LETTER_W+1)'(ALPHA_COUNT) - {1'b0, key};
		end else begin
			sum = {1'b0, plain} + {1'b0, key};
		end
		if (sum >= (LETTER_W+1)'(ALPHA_COUNT)) begin
			wrapped = sum - (LETTER_W+1)'(ALPHA_COUNT);
		end else begin
			wrapped = sum;
		end
	end

	always_comb begin
		if (is_upper || is_lower) begin
			result.out_byte   = CHAR_UPPER_A + 8'(wrapped);
			result.was_letter = 1'b1;
		end else begin
			result.out_byte   = in_byte;
			result.was_letter = 1'b0;
		end
	end

endmodule

// ===== rtl/vigenere_stream_cipher.sv =====
// Vigenere stream cipher: one text byte per transfer, one result per byte.
// Depends on vsc_pkg, vsc_cell and vsc_shift.
//
// The block takes one byte every clock cycle and returns its result in the cycle
// after the input transfer, through an output register that takes the next byte
// in the same cycle the waiting result is accepted; a stalled result stalls the
// input. The key position is a one-hot token in a row of
// KEY_MAX cells; each letter passes the token to the neighbor cell (wrapping at
// the key length) in the same cycle, which sets the one-byte-per-cycle rate.
// Letters of either case come out as shifted upper-case letters; other bytes
// pass through and keep the key position. Registers: 0 decrypt mode, 1 key
// length, 2 to 5 key letters 0-11, 12-23, 24-35, 36-47 at five bits each.
// Writes are always taken (cfg_ready stays high); indexes beyond 5 are dropped.
module vigenere_stream_cipher #(
	parameter int unsigned KEY_MAX = 48
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  vsc_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output vsc_pkg::out_item_t              out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [vsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vsc_pkg::WORD_W-1:0]      cfg_data
);
	import vsc_pkg::*;

	logic                   decrypt_mode_q;
	logic [POS_W-1:0]       key_length_q;
	logic [WORD_W-1:0]      key_words_q [KEY_WORDS];
	logic [KEY_FLAT_W-1:0]  key_flat;

	logic                   in_accept;
	logic [POS_W-1:0]       eff_len;
	logic                   step;
	cell_ctrl_t             ctrl;
	logic [KEY_MAX-1:0]     tok_live;
	logic [KEY_MAX-1:0]     stale_bits;
	logic [KEY_MAX-1:0]     last_bits;
	logic [LETTER_W-1:0]    key_bits [KEY_MAX];
	logic                   stale_any;
	logic                   wrap_tok;
	logic [LETTER_W-1:0]    key_cur;
	out_item_t              result;
	logic                   out_valid_q;
	out_item_t              out_data_q;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decrypt_mode_q <= 1'b0;
			key_length_q   <= POS_W'(1);
			for (int w = 0; w < KEY_WORDS; w++) begin
				key_words_q[w] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DECRYPT_MODE: decrypt_mode_q <= cfg_data[0];
				REG_KEY_LENGTH:   key_length_q   <= cfg_data[POS_W-1:0];
				REG_KEY_A:        key_words_q[0] <= cfg_data;
				REG_KEY_B:        key_words_q[1] <= cfg_data;
				REG_KEY_C:        key_words_q[2] <= cfg_data;
				REG_KEY_D:        key_words_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign key_flat = {key_words_q[3], key_words_q[2], key_words_q[1], key_words_q[0]};

	// Clamp the key length to 1..KEY_MAX
	always_comb begin
		if (key_length_q == '0) begin
			eff_len = POS_W'(1);
		end else if (key_length_q > POS_W'(KEY_MAX)) begin
			eff_len = POS_W'(KEY_MAX);
		end else begin
			eff_len = key_length_q;
		end
	end

	assign in_stall  = out_valid_q & out_stall;
	assign in_accept = in_valid & ~in_stall;
	assign ctrl      = '{restart: in_accept & in_data.msg_start, eff_len: eff_len};
	assign step      = in_accept & result.was_letter;

	assign stale_any = |stale_bits;
	assign wrap_tok  = |last_bits;

	// Row of key cells; the token moves one cell per letter
	for (genvar i = 0; i < KEY_MAX; i++) begin : g_cell
		vsc_cell #(
			.INDEX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.step     (step),
			.letter   (key_flat[i*LETTER_W +: LETTER_W]),
			.tok_in   ((i == 0) ? wrap_tok : tok_live[(i == 0) ? 0 : i-1]),
			.stale_in (stale_any),
			.tok_live (tok_live[i]),
			.stale_out(stale_bits[i]),
			.last_out (last_bits[i]),
			.key_out  (key_bits[i])
		);
	end

	// Only the token holder drives a nonzero letter
	always_comb begin
		key_cur = '0;
		for (int i = 0; i < KEY_MAX; i++) begin
			key_cur = key_cur | key_bits[i];
		end
	end

	vsc_shift u_shift (
		.in_byte(in_data.in_byte),
		.key    (key_cur),
		.decrypt(decrypt_mode_q),
		.result (result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!in_stall) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== tb/vigenere_stream_cipher_tb.sv =====
// Self-checking testbench for vigenere_stream_cipher: directed and random byte streams
// under varying idle patterns, checked against an in-bench cipher predictor.
// Depends on vsc_pkg and the vigenere_stream_cipher RTL.
module vigenere_stream_cipher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vsc_pkg::*;

	localparam int unsigned KEY_MAX = 48;

	// Indexes past the register list; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_0 = REG_KEY_D + 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_1 = REG_KEY_D + 3'd2;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	in_item_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0]    cfg_data  = '0;

	// Predictor state, mirrors the block after reset
	logic              dec_mode = 1'b0;
	logic [POS_W-1:0]  key_len  = POS_W'(1);
	logic [WORD_W-1:0] key_word [KEY_WORDS] = '{default: '0};
	logic [POS_W-1:0]  key_pos  = '0;

	out_item_t   expected_bytes[$];
	out_item_t   want;
	int unsigned src_gap_pct    = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned mismatches     = 0;
	int unsigned results_checked = 0;
	int unsigned letters_sent   = 0;
	int unsigned others_sent    = 0;
	int unsigned starts_sent    = 0;
	int unsigned reg_writes     = 0;

	vigenere_stream_cipher #(
		.KEY_MAX(KEY_MAX)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Run limit, far above the slowest correct run
	initial begin
		#5_000_000;
		$display("vigenere_stream_cipher_tb NOT OK");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("ERROR at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	// Cipher one byte and advance the key position
	function automatic out_item_t cipher_byte(input in_item_t item);
		int unsigned letter;
		int unsigned len;
		int unsigned pos;
		int unsigned k;
		out_item_t   res;
		if (item.msg_start)
			key_pos = '0;
		if (item.in_byte >= CHAR_UPPER_A && item.in_byte <= CHAR_UPPER_Z) begin
			letter = item.in_byte - CHAR_UPPER_A;
		end else if (item.in_byte >= CHAR_LOWER_A && item.in_byte <= CHAR_LOWER_Z) begin
			letter = item.in_byte - CHAR_LOWER_A;
		end else begin
			// non-letter passes through, key stays put
			res.out_byte   = item.in_byte;
			res.was_letter = 1'b0;
			return res;
		end
		len = (key_len == 0) ? 1 : key_len;
		if (len > KEY_MAX)
			len = KEY_MAX;
		// position left over from a longer key falls back to letter 0
		pos = key_pos;
		if (pos >= len)
			pos = 0;
		k = key_word[pos / LETTERS_PER_WORD][(pos % LETTERS_PER_WORD) * LETTER_W +: LETTER_W];
		if (k > ALPHA_COUNT - 1)
			k = ALPHA_COUNT - 1;
		if (dec_mode)
			letter = (letter + ALPHA_COUNT - k) % ALPHA_COUNT;
		else
			letter = (letter + k) % ALPHA_COUNT;
		pos++;
		if (pos >= len)
			pos = 0;
		key_pos        = POS_W'(pos);
		res.out_byte   = CHAR_UPPER_A + 8'(letter);
		res.was_letter = 1'b1;
		return res;
	endfunction

	// Result checker and random output stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_checked++;
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("result %h/%b with no byte pending",
					out_data.out_byte, out_data.was_letter));
			end else begin
				want = expected_bytes.pop_front();
				if (out_data.out_byte !== want.out_byte)
					report_mismatch($sformatf("out_byte %h, expected %h",
						out_data.out_byte, want.out_byte));
				if (out_data.was_letter !== want.was_letter)
					report_mismatch($sformatf("was_letter %b, expected %b (byte %h)",
						out_data.was_letter, want.was_letter, want.out_byte));
			end
		end
		out_stall <= ($urandom_range(99) < sink_stall_pct);
	end

	function automatic bit cipher_byte_is_letter(input logic [7:0] b);
		return (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ||
			(b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z);
	endfunction

	// One input transfer, with a random lead-in gap
	task automatic send_byte(input logic [7:0] b, input logic start);
		int unsigned gap;
		in_item_t    item;
		gap = 0;
		while ($urandom_range(99) < src_gap_pct && gap < 40)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.in_byte   = b;
		item.msg_start = start;
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (in_stall !== 1'b0);
		expected_bytes.push_back(cipher_byte(item));
		if (cipher_byte_is_letter(b))
			letters_sent++;
		else
			others_sent++;
		if (start)
			starts_sent++;
	endtask

	task automatic send_text(input string s, input logic start);
		int i;
		for (i = 0; i < s.len(); i++)
			send_byte(s[i], start && i == 0);
	endtask

	// Stop sending and wait until every result is back
	task automatic wait_results_done();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_bytes.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	// Register write; only called with the block idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_DECRYPT_MODE: dec_mode = data[0];
			REG_KEY_LENGTH:   key_len = data[POS_W-1:0];
			REG_KEY_A:        key_word[0] = data;
			REG_KEY_B:        key_word[1] = data;
			REG_KEY_C:        key_word[2] = data;
			REG_KEY_D:        key_word[3] = data;
			default: ;
		endcase
		reg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Random key setup, extremes included
	task automatic randomize_key_setup();
		logic [WORD_W-1:0] w;
		int i;
		write_reg(REG_DECRYPT_MODE, WORD_W'($urandom_range(1)));
		case ($urandom_range(7))
			0:       write_reg(REG_KEY_LENGTH, '0);
			1:       write_reg(REG_KEY_LENGTH, WORD_W'(1));
			2:       write_reg(REG_KEY_LENGTH, WORD_W'(KEY_MAX));
			3:       write_reg(REG_KEY_LENGTH, WORD_W'($urandom_range(63, KEY_MAX + 1)));
			default: write_reg(REG_KEY_LENGTH, WORD_W'($urandom_range(KEY_MAX, 1)));
		endcase
		for (i = 0; i < KEY_WORDS; i++) begin
			case ($urandom_range(7))
				0:       w = '0;
				1:       w = '1;
				default: w = WORD_W'({$urandom(), $urandom()});
			endcase
			write_reg(REG_KEY_A + CFG_IDX_W'(i), w);
		end
		if ($urandom_range(2) == 0)
			write_reg($urandom_range(1) ? REG_SPARE_1 : REG_SPARE_0,
				WORD_W'({$urandom(), $urandom()}));
	endtask

	// Reset values: key A, so letters only fold to upper case
	task automatic test_plain_defaults();
		logic [7:0] edge_bytes [10];
		int i;
		edge_bytes = '{8'h00, 8'hFF, CHAR_UPPER_A - 8'd1, CHAR_UPPER_A, CHAR_UPPER_Z,
			CHAR_UPPER_Z + 8'd1, CHAR_LOWER_A - 8'd1, CHAR_LOWER_A, CHAR_LOWER_Z,
			CHAR_LOWER_Z + 8'd1};
		for (i = 0; i < 10; i++)
			send_byte(edge_bytes[i], i[0]);
	endtask

	// Short key with saturated letters, wrap, restart, both modes
	task automatic test_key_wrap_saturation();
		wait_results_done();
		// letters: A, Z, 31 (sat to Z), 26 (sat to Z)
		write_reg(REG_KEY_A, 60'hD7F20);
		write_reg(REG_KEY_LENGTH, WORD_W'(4));
		write_reg(REG_DECRYPT_MODE, '0);
		send_text("zYmbq", 1'b1);
		send_byte("c", 1'b1);
		wait_results_done();
		write_reg(REG_DECRYPT_MODE, WORD_W'(1));
		send_text("AZa", 1'b1);
	endtask

	// Key length lowered under the position, length 0 and above max, spare indexes
	task automatic test_stale_position();
		wait_results_done();
		write_reg(REG_KEY_LENGTH, WORD_W'(KEY_MAX));
		write_reg(REG_KEY_B, '1);
		write_reg(REG_KEY_C, WORD_W'({$urandom(), $urandom()}));
		write_reg(REG_KEY_D, '1);
		send_text("QRST", 1'b1);
		wait_results_done();
		write_reg(REG_KEY_LENGTH, WORD_W'(2));
		send_text("ab", 1'b0);
		wait_results_done();
		write_reg(REG_KEY_LENGTH, '0);
		write_reg(REG_SPARE_0, '1);
		write_reg(REG_SPARE_1, '1);
		send_text("Hi!", 1'b0);
		wait_results_done();
		write_reg(REG_KEY_LENGTH, '1);
		send_text("xy", 1'b0);
	endtask

	// Random messages: mostly letters, some noise and restarts
	task automatic test_random_stream(input int unsigned n_items);
		int unsigned i;
		logic [7:0]  b;
		for (i = 0; i < n_items; i++) begin
			if (i % 50 == 0) begin
				wait_results_done();
				randomize_key_setup();
			end else if ($urandom_range(59) == 0) begin
				wait_results_done();
			end
			case ($urandom_range(9))
				0, 1, 2, 3: b = CHAR_UPPER_A + 8'($urandom_range(ALPHA_COUNT - 1));
				4, 5, 6:    b = CHAR_LOWER_A + 8'($urandom_range(ALPHA_COUNT - 1));
				default:    b = 8'($urandom_range(255));
			endcase
			send_byte(b, $urandom_range(19) == 0);
		end
	endtask

	// Main sequence
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_gap_pct    = 10;
		sink_stall_pct = 82;
		test_plain_defaults();
		test_key_wrap_saturation();
		test_stale_position();
		test_random_stream(300);

		src_gap_pct    = 82;
		sink_stall_pct = 10;
		test_random_stream(300);

		src_gap_pct    = 0;
		sink_stall_pct = 0;
		test_random_stream(300);

		wait_results_done();
		repeat (5) @(posedge clk);

		$display("Sent %0d letters, %0d other bytes, %0d message starts; %0d register writes",
			letters_sent, others_sent, starts_sent, reg_writes);
		$display("Checked %0d results over three idle patterns, %0d mismatches",
			results_checked, mismatches);
		if (mismatches == 0)
			$display("vigenere_stream_cipher_tb OK");
		else
			$display("vigenere_stream_cipher_tb NOT OK");
		$finish;
	end

endmodule
